// ===== rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator package
// Shared types, action codes and default sizes for the accumulator blocks.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int ACC_COUNT_DEF   = 32;
  localparam int CLIP_SCALE_DEF  = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int FEATURE_COUNT   = 20480;
  localparam int LANES           = 8;
  localparam int LANE_BITS       = 3;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD       = 3'd1,
    OP_SUB       = 3'd2,
    OP_EVAL      = 3'd3,
    OP_WR_SPARSE = 3'd4,
    OP_WR_BIAS   = 3'd5,
    OP_WR_DENSE  = 3'd6,
    OP_WR_PHASE  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         piece_kind;
    logic [5:0]         piece_square;
    logic [5:0]         king_square;
    logic               piece_color;
    logic               king_color;
    logic [14:0]        weight_row;
    logic [4:0]         weight_column;
    logic signed [15:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] midgame_score;
    logic signed [31:0] endgame_score;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [14:0]        feature;
    logic [4:0]         col;
    logic signed [15:0] value;
  } entry_t;

endpackage

// ===== rtl/sfa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator front end
// Accepts input transactions, computes the feature index and drops actions
// that have no effect.
// ----------------------------------------------------------------------------
module sfa_front #(
  parameter int ACC_COUNT = sfa_pkg::ACC_COUNT_DEF
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  sfa_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output sfa_pkg::entry_t  entry
);
  import sfa_pkg::*;

  logic [5:0]  sq;
  logic [5:0]  ksq;
  logic        pcol;
  logic [4:0]  ki;
  logic        keep;
  logic        col_ok;
  logic        row_ok;
  logic        accept;
  logic [14:0] feat;

  assign accept = in_valid && !in_stall;
  assign in_stall = q_full;

  always_comb begin
    sq   = in_data.piece_square;
    ksq  = in_data.king_square;
    pcol = in_data.piece_color;
    if (in_data.king_color) begin
      sq   = sq ^ 6'd56;
      ksq  = ksq ^ 6'd56;
      pcol = !pcol;
    end
    if (ksq[2]) begin
      sq  = sq ^ 6'd7;
      ksq = ksq ^ 6'd7;
    end
    ki   = {ksq[5:3], ksq[1:0]};
    feat = 15'(sq) + {6'd0, in_data.piece_kind, 6'd0} + {2'd0, ki, 8'd0}
         + {4'd0, ki, 6'd0} + (pcol ? 15'd10240 : 15'd0);
    col_ok = int'(in_data.weight_column) < ACC_COUNT;
    row_ok = int'(in_data.weight_row) < FEATURE_COUNT;
    entry.op    = op_t'(in_data.action);
    entry.col   = in_data.weight_column;
    entry.value = in_data.weight_value;
    entry.feature = in_data.weight_row;
    keep = 1'b1;
    case (entry.op)
      OP_ADD, OP_SUB: begin
        keep = in_data.piece_kind < 3'd5;
        entry.feature = feat;
      end
      OP_WR_SPARSE: keep = row_ok && col_ok;
      OP_WR_BIAS:   keep = col_ok;
      OP_WR_DENSE:  keep = (in_data.weight_row < 15'd2) && col_ok;
      OP_WR_PHASE:  keep = row_ok && (in_data.weight_column < 5'd2);
      default:      keep = 1'b1;
    endcase
  end

  assign push = accept && keep;

endmodule

// ===== rtl/sfa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator command queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module sfa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfa_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output sfa_pkg::entry_t head
);
  import sfa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full    = count_r == (PW+1)'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (PW+1)'(1)))
    else $error("queue count did not follow a push");

endmodule

// ===== rtl/sfa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator scale divider
// Divides a signed dot product by the clip scale through multiplication by
// a rounded-up reciprocal, 16 bits of magnitude per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module sfa_div #(
  parameter int DW         = 48,
  parameter int CLIP_SCALE = sfa_pkg::CLIP_SCALE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);
  localparam int SH  = DW + $clog2(CLIP_SCALE);
  localparam int MW  = DW + 1;
  localparam int PRW = SH + DW + 1;
  localparam int CH  = 16;
  localparam int NCH = (DW + CH - 1) / CH;
  localparam int XW  = NCH * CH;
  localparam int CNW = $clog2(NCH + 1);
  localparam logic [SH+1:0] RECIP =
    (((SH+2)'(1) << SH) + (SH+2)'(CLIP_SCALE - 1)) / (SH+2)'(CLIP_SCALE);

  logic [XW-1:0]    mag_r;
  logic [PRW-1:0]   prod_r;
  logic [CNW-1:0]   cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [DW-1:0]    abs_val;
  logic [CH+MW-1:0] part;
  logic [PRW-1:0]   prod_nxt;
  logic [DW-1:0]    mag_q;

  always_comb begin
    abs_val  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    part     = (CH+MW)'(mag_r[XW-1 -: CH]) * (CH+MW)'(RECIP[MW-1:0]);
    prod_nxt = (prod_r << CH) + PRW'(part);
    mag_q    = prod_r[SH +: DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(NCH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[DW-1];
      mag_r  <= XW'(abs_val);
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      mag_r  <= mag_r << CH;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(mag_q) : signed'(mag_q);

endmodule

// ===== rtl/sfa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator engine
// Holds the weight memories and the accumulator bank, applies commands from
// the queue eight lanes at a time and produces evaluation results.
// ----------------------------------------------------------------------------
module sfa_back #(
  parameter int ACC_COUNT   = sfa_pkg::ACC_COUNT_DEF,
  parameter int CLIP_SCALE  = sfa_pkg::CLIP_SCALE_DEF,
  parameter int WEIGHT_BITS = sfa_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sfa_pkg::entry_t    q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sfa_pkg::out_item_t out_data
);
  import sfa_pkg::*;

  localparam int WB      = WEIGHT_BITS;
  localparam int GROUPS  = (ACC_COUNT + LANES - 1) / LANES;
  localparam int ACC_PAD = GROUPS * LANES;
  localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SAW     = $clog2(FEATURE_COUNT * GROUPS);
  localparam int FW      = $clog2(FEATURE_COUNT);
  localparam int CW      = $clog2(CLIP_SCALE + 1);
  localparam int PW      = WB + CW + 1;
  localparam int DW      = PW + $clog2(ACC_PAD) + 1;

  state_t state_r, state_nxt;
  logic [GW-1:0] cnt_r, cnt_nxt;
  logic          wr_en;
  logic          run_issue;
  logic          div_start;
  logic          out_load;
  logic          dot_clr;

  logic signed [WB-1:0] sp_mem [LANES][FEATURE_COUNT * GROUPS];
  logic signed [WB-1:0] dn0_mem [LANES][GROUPS];
  logic signed [WB-1:0] dn1_mem [LANES][GROUPS];
  logic signed [WB-1:0] bias_mem [LANES][GROUPS];
  logic signed [WB-1:0] ph_mem [2][FEATURE_COUNT];

  logic signed [WB-1:0] sp_rd_r [LANES];
  logic signed [WB-1:0] dn0_rd_r [LANES];
  logic signed [WB-1:0] dn1_rd_r [LANES];
  logic signed [WB-1:0] bias_rd_r [LANES];
  logic signed [WB-1:0] ph_rd_r [2];

  logic [31:0]          acc_r [ACC_PAD];
  logic [31:0]          ph_sum_r [2];
  logic                 rd_vld_r;
  logic                 rd_first_r;
  logic [GW-1:0]        rd_grp_r;
  logic                 prod_vld_r;
  logic signed [PW-1:0] prod0_r [LANES];
  logic signed [PW-1:0] prod1_r [LANES];
  logic signed [DW-1:0] dot0_r;
  logic signed [DW-1:0] dot1_r;
  logic signed [DW-1:0] sum0;
  logic signed [DW-1:0] sum1;
  logic                 div_done;
  logic                 div_done_eg;
  logic signed [DW-1:0] quot0;
  logic signed [DW-1:0] quot1;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic signed [WB-1:0] w_fit;
  logic [LANE_BITS-1:0] wr_lane;
  logic [GW-1:0]        wr_grp;
  logic [4:0]           col_hi;
  logic [SAW-1:0]       wr_addr;
  logic [SAW-1:0]       rd_addr;
  logic                 is_eval;
  logic [CW-1:0]        clip [LANES];

  assign is_eval = q_head.op == OP_EVAL;
  assign w_fit   = WB'(q_head.value);
  assign wr_lane = q_head.col[LANE_BITS-1:0];
  assign col_hi  = q_head.col >> LANE_BITS;
  assign wr_grp  = GW'(col_hi);
  assign wr_addr = SAW'(int'(q_head.feature) * GROUPS + int'(wr_grp));
  assign rd_addr = SAW'(int'(q_head.feature) * GROUPS + int'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    run_issue = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    dot_clr   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.op inside {OP_WR_SPARSE, OP_WR_BIAS, OP_WR_DENSE, OP_WR_PHASE}) begin
            wr_en = 1'b1;
            pop   = 1'b1;
          end else begin
            state_nxt = ST_RUN;
            cnt_nxt   = '0;
            dot_clr   = 1'b1;
          end
        end
      end
      ST_RUN: begin
        run_issue = 1'b1;
        if (cnt_r == GW'(GROUPS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + GW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) begin
          if (is_eval) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            pop       = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          pop       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (wr_en && wr_lane == LANE_BITS'(l)) begin
        if (q_head.op == OP_WR_SPARSE) begin
          sp_mem[l][wr_addr] <= w_fit;
        end
        if (q_head.op == OP_WR_BIAS) begin
          bias_mem[l][wr_grp] <= w_fit;
        end
        if (q_head.op == OP_WR_DENSE && !q_head.feature[0]) begin
          dn0_mem[l][wr_grp] <= w_fit;
        end
        if (q_head.op == OP_WR_DENSE && q_head.feature[0]) begin
          dn1_mem[l][wr_grp] <= w_fit;
        end
      end
      sp_rd_r[l]   <= sp_mem[l][rd_addr];
      bias_rd_r[l] <= bias_mem[l][cnt_r];
      dn0_rd_r[l]  <= dn0_mem[l][cnt_r];
      dn1_rd_r[l]  <= dn1_mem[l][cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 2; p++) begin
      if (wr_en && q_head.op == OP_WR_PHASE && q_head.col[0] == 1'(p)) begin
        ph_mem[p][FW'(q_head.feature)] <= w_fit;
      end
      ph_rd_r[p] <= ph_mem[p][FW'(q_head.feature)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= run_issue;
      rd_first_r <= run_issue && cnt_r == '0;
      prod_vld_r <= rd_vld_r && is_eval;
    end
    rd_grp_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ACC_PAD; i++) begin
        acc_r[i] <= '0;
      end
      ph_sum_r[0] <= '0;
      ph_sum_r[1] <= '0;
    end else if (rd_vld_r) begin
      for (int i = 0; i < ACC_PAD - LANES; i++) begin
        acc_r[i] <= acc_r[i + LANES];
      end
      for (int l = 0; l < LANES; l++) begin
        case (q_head.op)
          OP_CLEAR: acc_r[ACC_PAD - LANES + l] <= 32'(bias_rd_r[l]);
          OP_ADD:   acc_r[ACC_PAD - LANES + l] <= acc_r[l] + 32'(sp_rd_r[l]);
          OP_SUB:   acc_r[ACC_PAD - LANES + l] <= acc_r[l] - 32'(sp_rd_r[l]);
          default:  acc_r[ACC_PAD - LANES + l] <= acc_r[l];
        endcase
      end
      if (rd_first_r) begin
        for (int p = 0; p < 2; p++) begin
          case (q_head.op)
            OP_CLEAR: ph_sum_r[p] <= '0;
            OP_ADD:   ph_sum_r[p] <= ph_sum_r[p] + 32'(ph_rd_r[p]);
            OP_SUB:   ph_sum_r[p] <= ph_sum_r[p] - 32'(ph_rd_r[p]);
            default:  ph_sum_r[p] <= ph_sum_r[p];
          endcase
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (int'(rd_grp_r) * LANES + l >= ACC_COUNT || acc_r[l][31]) begin
        clip[l] = '0;
      end else if (acc_r[l] > 32'(CLIP_SCALE)) begin
        clip[l] = CW'(CLIP_SCALE);
      end else begin
        clip[l] = CW'(acc_r[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      prod0_r[l] <= PW'(dn0_rd_r[l]) * PW'(signed'({1'b0, clip[l]}));
      prod1_r[l] <= PW'(dn1_rd_r[l]) * PW'(signed'({1'b0, clip[l]}));
    end
  end

  always_comb begin
    sum0 = dot0_r;
    sum1 = dot1_r;
    for (int l = 0; l < LANES; l++) begin
      sum0 = sum0 + DW'(prod0_r[l]);
      sum1 = sum1 + DW'(prod1_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (dot_clr) begin
      dot0_r <= '0;
      dot1_r <= '0;
    end else if (prod_vld_r) begin
      dot0_r <= sum0;
      dot1_r <= sum1;
    end
  end

  sfa_div #(
    .DW         (DW),
    .CLIP_SCALE (CLIP_SCALE)
  ) u_div_mg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dot0_r),
    .done     (div_done),
    .quotient (quot0)
  );

  sfa_div #(
    .DW         (DW),
    .CLIP_SCALE (CLIP_SCALE)
  ) u_div_eg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dot1_r),
    .done     (div_done_eg),
    .quotient (quot1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r.midgame_score <= signed'(ph_sum_r[0] + 32'(quot0));
      out_data_r.endgame_score <= signed'(ph_sum_r[1] + 32'(quot1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN || state_r == ST_DRAIN) |-> q_valid)
    else $error("engine running without a queued command");
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (is_eval && !rd_vld_r && !prod_vld_r))
    else $error("divider started before the dot product settled");
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_done_eg)
    else $error("phase dividers out of step");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

endmodule

// ===== rtl/sparse_feature_accumulator_eval_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator evaluation unit
// Incremental chess feature accumulator with clipped dense evaluation.
// ----------------------------------------------------------------------------
// The engine applies each weight write directly from its idle state. Clear,
// add and remove walk the accumulator bank eight lanes per cycle through the
// banked sparse weight memory. Evaluate takes the same walk, then finishes
// the dot product, runs a scale divider that multiplies by the reciprocal of
// the clip scale, 16 bits of dot-product width per cycle, and loads the
// result. A four-entry command queue lets new transactions be taken while
// the engine works, and a result register holds each score pair until it
// is taken. Add and remove with a king piece and writes outside a table
// are dropped at the input. Weight memories are not cleared by reset and
// must be loaded before use.
module sparse_feature_accumulator_eval_unit #(
  parameter int ACC_COUNT   = sfa_pkg::ACC_COUNT_DEF,
  parameter int CLIP_SCALE  = sfa_pkg::CLIP_SCALE_DEF,
  parameter int WEIGHT_BITS = sfa_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfa_pkg::out_item_t out_data
);
  import sfa_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   q_valid;
  entry_t q_head;

  sfa_front #(
    .ACC_COUNT (ACC_COUNT)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_data)
  );

  sfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  sfa_back #(
    .ACC_COUNT   (ACC_COUNT),
    .CLIP_SCALE  (CLIP_SCALE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse feature accumulator evaluation unit testbench
// Loads biases, dense weights and the weights of a pool of piece placements,
// then runs directed and random add, remove, clear, evaluate and write
// transactions with random idling on both sides. A scoreboard predicts every
// score pair and compares it with the block's results.
// ----------------------------------------------------------------------------
module testbench;
  import sfa_pkg::*;

  localparam int NUM_ACC    = 32;
  localparam int SCALE      = 64;
  localparam int KING_KIND  = 5;
  localparam int POOL_SIZE  = 14;
  localparam int RAND_ITEMS = 650;

  function automatic int feature_index(in_item_t it);
    bit [5:0] sq;
    bit [5:0] ksq;
    bit pc;
    sq = it.piece_square;
    ksq = it.king_square;
    pc = it.piece_color;
    if (it.king_color) begin
      pc = ~pc;
      sq ^= 6'd56;
      ksq ^= 6'd56;
    end
    if (ksq[2:0] >= 4) begin
      sq ^= 6'd7;
      ksq ^= 6'd7;
    end
    return sq + 64*it.piece_kind + 320*(4*ksq[5:3] + ksq[2:0]) + 10240*pc;
  endfunction

  class score_board;
    int sparse_w[int];
    int phase_w[int];
    int dense_w[2*NUM_ACC];
    int bias_w[NUM_ACC];
    bit [31:0] acc[NUM_ACC];
    bit [31:0] phase_sum[2];
    out_item_t pending[$];
    int errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      phase_sum[0] = '0;
      phase_sum[1] = '0;
      errors = 0;
    endfunction

    function void note(in_item_t it);
      int f;
      longint dot[2];
      longint c;
      int a;
      out_item_t res;
      case (op_t'(it.action))
        OP_CLEAR: begin
          foreach (acc[i]) acc[i] = bias_w[i];
          phase_sum[0] = '0;
          phase_sum[1] = '0;
        end
        OP_ADD, OP_SUB: begin
          if (it.piece_kind < KING_KIND) begin
            f = feature_index(it);
            for (int i = 0; i < NUM_ACC; i++) begin
              if (it.action == OP_ADD) acc[i] += sparse_w[i*FEATURE_COUNT+f];
              else acc[i] -= sparse_w[i*FEATURE_COUNT+f];
            end
            for (int p = 0; p < 2; p++) begin
              if (it.action == OP_ADD) phase_sum[p] += phase_w[p*FEATURE_COUNT+f];
              else phase_sum[p] -= phase_w[p*FEATURE_COUNT+f];
            end
          end
        end
        OP_EVAL: begin
          dot[0] = 0;
          dot[1] = 0;
          for (int i = 0; i < NUM_ACC; i++) begin
            a = acc[i];
            c = a < 0 ? 0 : (a > SCALE ? SCALE : a);
            dot[0] += longint'(dense_w[i]) * c;
            dot[1] += longint'(dense_w[NUM_ACC+i]) * c;
          end
          res.midgame_score = phase_sum[0] + 32'(dot[0] / SCALE);
          res.endgame_score = phase_sum[1] + 32'(dot[1] / SCALE);
          pending.push_back(res);
        end
        OP_WR_SPARSE:
          if (it.weight_row < FEATURE_COUNT)
            sparse_w[it.weight_column*FEATURE_COUNT+it.weight_row] = it.weight_value;
        OP_WR_BIAS: bias_w[it.weight_column] = it.weight_value;
        OP_WR_DENSE:
          if (it.weight_row < 2) dense_w[it.weight_row*NUM_ACC+it.weight_column] = it.weight_value;
        default:
          if (it.weight_row < FEATURE_COUNT && it.weight_column < 2)
            phase_w[it.weight_column*FEATURE_COUNT+it.weight_row] = it.weight_value;
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result mid=%0d end=%0d",
                                   got.midgame_score, got.endgame_score);
        return;
      end
      exp_res = pending.pop_front();
      if (got.midgame_score !== exp_res.midgame_score ||
          got.endgame_score !== exp_res.endgame_score) begin
        errors++;
        if (errors <= 10)
          $display("score mismatch: expected mid=%0d end=%0d, got mid=%0d end=%0d",
                   exp_res.midgame_score, exp_res.endgame_score,
                   got.midgame_score, got.endgame_score);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  score_board sb;
  in_item_t pool[POOL_SIZE];
  bit quiet;
  bit hold_req;
  bit done;

  sparse_feature_accumulator_eval_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  task automatic send(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(it);
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t blank(op_t op);
    in_item_t it;
    it = '0;
    it.action = op;
    return it;
  endfunction

  function automatic in_item_t wr(op_t op, int row, int col, int val);
    in_item_t it;
    it = blank(op);
    it.weight_row = 15'(row);
    it.weight_column = 5'(col);
    it.weight_value = 16'(val);
    return it;
  endfunction

  function automatic int small_weight();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 40)) - 20;
  endfunction

  task automatic load_feature(int f);
    for (int c = 0; c < NUM_ACC; c++) send(wr(OP_WR_SPARSE, f, c, small_weight()));
    for (int p = 0; p < 2; p++) send(wr(OP_WR_PHASE, f, p, small_weight()));
  endtask

  function automatic in_item_t piece(op_t op);
    in_item_t it;
    it = pool[$urandom_range(0, POOL_SIZE-1)];
    it.action = op;
    it.weight_row = 15'($urandom_range(0, 32767));
    it.weight_column = 5'($urandom_range(0, 31));
    it.weight_value = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) it = piece(OP_ADD);
    else if (r < 60) it = piece(OP_SUB);
    else if (r < 76) it = blank(OP_EVAL);
    else if (r < 79) it = blank(OP_CLEAR);
    else if (r < 82) begin
      it = piece(OP_ADD);
      it.action = ($urandom_range(0, 1) == 1) ? OP_ADD : OP_SUB;
      it.piece_kind = 3'($urandom_range(KING_KIND, 7));
    end else if (r < 86)
      it = wr(OP_WR_SPARSE, feature_index(piece(OP_ADD)), $urandom_range(0, 31),
              small_weight());
    else if (r < 89)
      it = wr(OP_WR_PHASE, feature_index(piece(OP_ADD)), $urandom_range(0, 1),
              small_weight());
    else if (r < 92)
      it = wr(OP_WR_SPARSE, $urandom_range(0, 32767), $urandom_range(0, 31),
              small_weight());
    else if (r < 94)
      it = wr(OP_WR_PHASE, $urandom_range(0, 32767), $urandom_range(0, 31),
              small_weight());
    else if (r < 97)
      it = wr(OP_WR_BIAS, $urandom_range(0, 32767), $urandom_range(0, 31), small_weight());
    else
      it = wr(OP_WR_DENSE, $urandom_range(0, 3), $urandom_range(0, 31), small_weight());
    if (it.action == OP_EVAL || it.action == OP_CLEAR) begin
      it.piece_kind = 3'($urandom_range(0, 7));
      it.weight_row = 15'($urandom_range(0, 32767));
    end
    send(it);
  endtask

  initial begin
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int k;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      k = quiet ? 0 : $urandom_range(0, 7);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && !hold_req) @(posedge clk);
    end
  end

  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_item_t it;
    int waited;
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int c = 0; c < NUM_ACC; c++) send(wr(OP_WR_BIAS, 0, c, small_weight()));
    for (int c = 0; c < 2*NUM_ACC; c++)
      send(wr(OP_WR_DENSE, c / NUM_ACC, c % NUM_ACC, int'($urandom_range(0, 65535)) - 32768));
    send(wr(OP_WR_DENSE, 1, 31, -32768));
    send(wr(OP_WR_DENSE, 0, 0, 32767));

    // Corner placements first, then random ones.
    pool[0] = '{action: OP_ADD, piece_kind: 0, piece_square: 0, king_square: 0,
                piece_color: 0, king_color: 0, default: '0};
    pool[1] = '{action: OP_ADD, piece_kind: 4, piece_square: 63, king_square: 63,
                piece_color: 1, king_color: 1, default: '0};
    pool[2] = '{action: OP_ADD, piece_kind: 4, piece_square: 63, king_square: 7,
                piece_color: 1, king_color: 0, default: '0};
    pool[3] = '{action: OP_ADD, piece_kind: 0, piece_square: 0, king_square: 56,
                piece_color: 0, king_color: 1, default: '0};
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool[i] = '0;
      pool[i].piece_kind = 3'($urandom_range(0, 4));
      pool[i].piece_square = 6'($urandom_range(0, 63));
      pool[i].king_square = 6'($urandom_range(0, 63));
      pool[i].piece_color = 1'($urandom_range(0, 1));
      pool[i].king_color = 1'($urandom_range(0, 1));
    end
    for (int i = 0; i < POOL_SIZE; i++) load_feature(feature_index(pool[i]));

    // Directed transactions.
    send(blank(OP_EVAL));
    send(blank(OP_CLEAR));
    send(blank(OP_EVAL));
    for (int i = 0; i < 4; i++) begin
      it = pool[i];
      it.action = OP_ADD;
      send(it);
    end
    send(blank(OP_EVAL));
    it = pool[1];
    it.action = OP_SUB;
    send(it);
    it.piece_kind = KING_KIND;
    send(it);
    it.piece_kind = 7;
    it.action = OP_ADD;
    send(it);
    send(blank(OP_EVAL));
    send(wr(OP_WR_SPARSE, 20480, 0, 12345));
    send(wr(OP_WR_SPARSE, 32767, 31, -1));
    send(wr(OP_WR_PHASE, 20479, 2, 7));
    send(wr(OP_WR_PHASE, feature_index(pool[0]), 1, 32767));
    send(wr(OP_WR_SPARSE, feature_index(pool[0]), 31, -32768));
    send(wr(OP_WR_DENSE, 2, 5, 99));
    it = pool[0];
    it.action = OP_ADD;
    repeat (3) send(it);
    send(blank(OP_EVAL));
    send(blank(OP_CLEAR));
    send(blank(OP_EVAL));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 300 == 0) quiet = ~quiet;
      if (n == 600) begin
        hold_req = 1'b1;
        repeat (30) send(blank(OP_EVAL));
      end
      random_item();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/sfa_pkg.sv
rtl/sfa_front.sv
rtl/sfa_queue.sv
rtl/sfa_div.sv
rtl/sfa_back.sv
rtl/sparse_feature_accumulator_eval_unit.sv
dv/testbench.sv
